/* rtl/chacha20_stream_cipher_unit_macros.svh */
// ----------------------------------------------------------------------------
// chacha20 stream cipher unit assertion macros
// shared property wrappers for the cipher unit checks
// ----------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_CIPHER_UNIT_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CC20_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CC20_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cc20_pkg.sv */
// ----------------------------------------------------------------------------
// cc20_pkg
// shared types and constants of the chacha20 stream cipher unit
// ----------------------------------------------------------------------------
package cc20_pkg;

    // number of double rounds per keystream block
    localparam int CC_DOUBLE_ROUNDS = 10;

    // words in one cipher state
    localparam int CC_WORDS = 16;

    // full cipher state, word i in element i
    typedef logic [CC_WORDS-1:0][31:0] t_state;

    // control of the shared round unit: column or diagonal pass, step of the quarter round
    typedef struct packed {
        logic       diag;
        logic [1:0] step;
    } t_round_ctl;

    // configuration register indexes, 8 bytes apart on the apb port
    typedef enum logic [2:0] {
        REG_KEY_0_7,
        REG_KEY_8_15,
        REG_KEY_16_23,
        REG_KEY_24_31,
        REG_NONCE_0_7,
        REG_NONCE_8_11,
        REG_INIT_CTR
    } t_cfg_reg;

endpackage

/* rtl/cc20_round_unit.sv */
// ----------------------------------------------------------------------------
// cc20_round_unit
// one quarter-round step applied to four lanes at once (columns or diagonals)
// ----------------------------------------------------------------------------
module cc20_round_unit (
    input  cc20_pkg::t_state     i_x,
    input  cc20_pkg::t_round_ctl i_ctl,
    output cc20_pkg::t_state     o_x
);
    import cc20_pkg::*;

    // step codes of one quarter round
    localparam logic [1:0] STEP_AB_D16 = 2'd0;
    localparam logic [1:0] STEP_CD_B12 = 2'd1;
    localparam logic [1:0] STEP_AB_D8  = 2'd2;
    localparam logic [1:0] STEP_CD_B7  = 2'd3;

    // fixed left rotation chosen by the step
    function automatic logic [31:0] rot_by_step(input logic [31:0] v, input logic [1:0] step);
        logic [31:0] r;
        unique case (step)
            STEP_AB_D16: r = {v[15:0], v[31:16]};
            STEP_CD_B12: r = {v[19:0], v[31:20]};
            STEP_AB_D8:  r = {v[23:0], v[31:24]};
            STEP_CD_B7:  r = {v[24:0], v[31:25]};
            default:     r = v;
        endcase
        return r;
    endfunction

    // four independent lanes, each one add, xor and rotate
    always_comb begin
        logic [3:0]  idx_a;
        logic [3:0]  idx_b;
        logic [3:0]  idx_c;
        logic [3:0]  idx_d;
        logic [31:0] sum;
        logic [31:0] mix;
        o_x = i_x;
        for (int lane = 0; lane < 4; lane++) begin
            idx_a = 4'(lane);
            idx_b = {2'b01, 2'(lane + int'(i_ctl.diag))};
            idx_c = {2'b10, 2'(lane + 2 * int'(i_ctl.diag))};
            idx_d = {2'b11, 2'(lane + 3 * int'(i_ctl.diag))};
            if (!i_ctl.step[0]) begin
                sum = i_x[idx_a] + i_x[idx_b];
                mix = rot_by_step(i_x[idx_d] ^ sum, i_ctl.step);
                o_x[idx_a] = sum;
                o_x[idx_d] = mix;
            end else begin
                sum = i_x[idx_c] + i_x[idx_d];
                mix = rot_by_step(i_x[idx_b] ^ sum, i_ctl.step);
                o_x[idx_c] = sum;
                o_x[idx_b] = mix;
            end
        end
    end

endmodule

/* rtl/chacha20_stream_cipher_unit.sv */
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_unit
// chacha20 encrypt/decrypt of a byte stream, up to eight bytes per transaction
// ----------------------------------------------------------------------------
// usage:
//   input channel carries up to eight message bytes, a byte count and a first
//   flag; output channel returns the bytes xored with keystream plus the count.
//   key, nonce and initial counter come over the apb port; the user must write
//   them only while idle, the unit does not enforce it. a transaction is
//   accepted only in the idle state, one at a time.
// sequence: a reused keystream block goes straight from idle to output; a new
//   block takes a load state, 8*DOUBLE_ROUNDS steps of the shared quarter-round
//   unit (four lanes, one add/xor/rotate step per cycle) and a feed-forward
//   state before output. eight transactions share each 64-byte keystream block.
// reset clears the configuration, block counter, slot and keystream flag;
//   the next transaction then builds a fresh block.
// a stalled result holds in the output register; the unit stays busy with
//   the next transaction until that register frees up.
// ----------------------------------------------------------------------------
`include "chacha20_stream_cipher_unit_macros.svh"

module chacha20_stream_cipher_unit #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::CC_DOUBLE_ROUNDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_message_bytes,
    input  logic [3:0]  i_byte_count,
    input  logic        i_first,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_result_bytes,
    output logic [3:0]  o_result_count,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import cc20_pkg::*;

    localparam int DR_W = $clog2(DOUBLE_ROUNDS);

    // chacha constants
    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ROUND,
        S_FEED,
        S_OUT
    } t_fsm;

    // configuration registers
    logic [63:0] r_key_0_7;
    logic [63:0] r_key_8_15;
    logic [63:0] r_key_16_23;
    logic [63:0] r_key_24_31;
    logic [63:0] r_nonce_0_7;
    logic [31:0] r_nonce_8_11;
    logic [31:0] r_init_ctr;

    // control state
    t_fsm            r_state;
    logic [DR_W-1:0] r_dr;
    t_round_ctl      r_ctl;
    logic [31:0]     r_ctr;
    logic [2:0]      r_slot;
    logic            r_ks_ready;
    logic            r_out_valid;

    // payload
    t_state      r_x;
    logic [63:0] r_msg;
    logic [3:0]  r_count;
    logic [63:0] r_result_bytes;
    logic [3:0]  r_result_count;

    t_state      n_round_x;
    t_state      w_init;
    logic        w_cfg_wr;
    logic [2:0]  w_reg_idx;
    logic        w_out_free;
    logic [63:0] w_ks;
    logic [63:0] w_mask;

    // apb decode
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[5:3];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (w_reg_idx)
            REG_KEY_0_7:    prdata = r_key_0_7;
            REG_KEY_8_15:   prdata = r_key_8_15;
            REG_KEY_16_23:  prdata = r_key_16_23;
            REG_KEY_24_31:  prdata = r_key_24_31;
            REG_NONCE_0_7:  prdata = r_nonce_0_7;
            REG_NONCE_8_11: prdata = {32'd0, r_nonce_8_11};
            REG_INIT_CTR:   prdata = {32'd0, r_init_ctr};
            default:        prdata = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_0_7    <= 64'd0;
            r_key_8_15   <= 64'd0;
            r_key_16_23  <= 64'd0;
            r_key_24_31  <= 64'd0;
            r_nonce_0_7  <= 64'd0;
            r_nonce_8_11 <= 32'd0;
            r_init_ctr   <= 32'd0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_KEY_0_7:    r_key_0_7    <= pwdata;
                REG_KEY_8_15:   r_key_8_15   <= pwdata;
                REG_KEY_16_23:  r_key_16_23  <= pwdata;
                REG_KEY_24_31:  r_key_24_31  <= pwdata;
                REG_NONCE_0_7:  r_nonce_0_7  <= pwdata;
                REG_NONCE_8_11: r_nonce_8_11 <= pwdata[31:0];
                REG_INIT_CTR:   r_init_ctr   <= pwdata[31:0];
                default:        ;
            endcase
        end
    end

    // initial block state from constants, key, counter and nonce
    always_comb begin
        w_init[0]  = SIGMA_0;
        w_init[1]  = SIGMA_1;
        w_init[2]  = SIGMA_2;
        w_init[3]  = SIGMA_3;
        w_init[4]  = r_key_0_7[31:0];
        w_init[5]  = r_key_0_7[63:32];
        w_init[6]  = r_key_8_15[31:0];
        w_init[7]  = r_key_8_15[63:32];
        w_init[8]  = r_key_16_23[31:0];
        w_init[9]  = r_key_16_23[63:32];
        w_init[10] = r_key_24_31[31:0];
        w_init[11] = r_key_24_31[63:32];
        w_init[12] = r_ctr;
        w_init[13] = r_nonce_0_7[31:0];
        w_init[14] = r_nonce_0_7[63:32];
        w_init[15] = r_nonce_8_11;
    end

    // shared quarter-round step unit
    cc20_round_unit u_round (
        .i_x   (r_x),
        .i_ctl (r_ctl),
        .o_x   (n_round_x)
    );

    // keystream pair for the current slot and valid byte mask
    assign w_ks = {r_x[{r_slot, 1'b1}], r_x[{r_slot, 1'b0}]};

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_mask[b*8 +: 8] = (4'(b) < r_count) ? 8'hFF : 8'h00;
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    // sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dr        <= '0;
            r_ctl       <= '0;
            r_ctr       <= 32'd0;
            r_slot      <= 3'd0;
            r_ks_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // result taken and no new one loaded this cycle
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_msg   <= i_message_bytes;
                        r_count <= i_byte_count;
                        if (i_first) begin
                            r_ctr      <= r_init_ctr;
                            r_slot     <= 3'd0;
                            r_ks_ready <= 1'b0;
                        end
                        if (i_first || r_slot == 3'd0 || !r_ks_ready) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_LOAD: begin
                    r_x     <= w_init;
                    r_dr    <= '0;
                    r_ctl   <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_x   <= n_round_x;
                    r_ctl <= t_round_ctl'(3'(r_ctl) + 3'd1);
                    if (&r_ctl) begin
                        if (r_dr == DR_W'(DOUBLE_ROUNDS - 1)) begin
                            r_state <= S_FEED;
                        end else begin
                            r_dr <= r_dr + DR_W'(1);
                        end
                    end
                end
                S_FEED: begin
                    for (int i = 0; i < CC_WORDS; i++) begin
                        r_x[i] <= r_x[i] + w_init[i];
                    end
                    r_ctr      <= r_ctr + 32'd1;
                    r_ks_ready <= 1'b1;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid    <= 1'b1;
                        r_result_bytes <= (r_msg ^ w_ks) & w_mask;
                        r_result_count <= r_count;
                        r_slot         <= r_slot + 3'd1;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_result_bytes = r_result_bytes;
    assign o_result_count = r_result_count;

    // checks
    `CC20_ASSERT_SAME(a_out_needs_keystream, i_clk, i_rst_n, r_state == S_OUT, r_ks_ready, "result produced without a built keystream block")
    `CC20_ASSERT_NEXT(a_feed_sets_ready, i_clk, i_rst_n, r_state == S_FEED, r_ks_ready && r_state == S_OUT, "feed-forward did not mark keystream ready")
    `CC20_ASSERT_NEXT(a_feed_bumps_counter, i_clk, i_rst_n, r_state == S_FEED, r_ctr == 32'($past(r_ctr) + 32'd1), "block counter did not advance after a block")
    `CC20_ASSERT_SAME(a_round_count_range, i_clk, i_rst_n, r_state == S_ROUND, int'(r_dr) < DOUBLE_ROUNDS, "double round counter out of range")
    `CC20_ASSERT_NEXT(a_out_loads_result, i_clk, i_rst_n, r_state == S_OUT && w_out_free, o_out_valid && r_state == S_IDLE, "free output register not loaded")

endmodule
